[design/prsa_pkg.sv]
package prsa_pkg;

  localparam int unsigned ADDR_W = 52;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    RT_USABLE         = 3'd0,
    RT_RESERVED       = 3'd1,
    RT_ACPI_RECLAIM   = 3'd2,
    RT_ACPI_NVS       = 3'd3,
    RT_BAD            = 3'd4,
    RT_LOADER_RECLAIM = 3'd5,
    RT_KERNEL         = 3'd6,
    RT_FRAMEBUFFER    = 3'd7
  } rtype_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } seq_state_t;

  // update request from the sequencer to the statistics unit
  typedef struct packed {
    logic   en;
    op_t    op;
    rtype_t rtype;
  } tot_ctl_t;

  typedef struct packed {
    logic [ADDR_W-1:0] overall;
    logic [ADDR_W-1:0] usable;
    logic [ADDR_W-1:0] reserved;
    logic [ADDR_W-1:0] bad;
    logic [ADDR_W-1:0] kernel;
    logic [ADDR_W-1:0] framebuffer;
    logic [ADDR_W-1:0] reclaimable;
  } tot_t;

  function automatic logic [ADDR_W-1:0] sat_add(input logic [ADDR_W-1:0] a,
                                                input logic [ADDR_W-1:0] b);
    logic [ADDR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ADDR_W] ? {ADDR_W{1'b1}} : s[ADDR_W-1:0];
  endfunction

endpackage

[design/page_run_stack_allocator.sv]
// Page run stack allocator.
// Input channel (in_valid/in_ready) carries one request beat: add a memory
// map region, allocate a page or free a page. Every request yields exactly
// one result beat on the output channel (out_valid/out_ready): the frame
// base (zero unless an allocation succeeded), a status code and all
// seven byte totals as they stand after the request.
// Free runs (base, length) live in one RAM, base and length side by side,
// used as a LIFO indexed by the run count.
// A request is accepted in the idle state, where an allocation also launches
// the top-of-stack read; the execute state then does the write-back and
// loads the result register. No new request is taken until the previous one
// leaves execute, as the registered run RAM read precedes the write-back.
// A finished result may wait in the output register while the next request
// is accepted; that request then holds in its execute cycle until the result
// register drains, so a stalled receiver backs up onto in_ready.
// Reset (synchronous, rst_n low) empties the stack and clears the totals;
// RAM contents are left as they are and only entries below the count are read.
module page_run_stack_allocator import prsa_pkg::*; #(
  parameter int unsigned RUN_DEPTH  = 64,
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  logic              clk,
  input  logic              rst_n,

  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_operation,
  input  logic [2:0]        in_region_type,
  input  logic [ADDR_W-1:0] in_address,
  input  logic [ADDR_W-1:0] in_region_bytes,

  output logic              out_valid,
  input  logic              out_ready,
  output logic [ADDR_W-1:0] out_frame_base,
  output logic [1:0]        out_status,
  output logic [ADDR_W-1:0] out_overall_bytes,
  output logic [ADDR_W-1:0] out_usable_bytes,
  output logic [ADDR_W-1:0] out_reserved_bytes,
  output logic [ADDR_W-1:0] out_bad_bytes,
  output logic [ADDR_W-1:0] out_kernel_bytes,
  output logic [ADDR_W-1:0] out_framebuffer_bytes,
  output logic [ADDR_W-1:0] out_reclaimable_bytes
);

  localparam int unsigned AW = $clog2(RUN_DEPTH);
  localparam int unsigned CW = $clog2(RUN_DEPTH + 1);
  localparam int unsigned RW = 2 * ADDR_W;
  localparam logic [ADDR_W-1:0] PAGE_LEN = ADDR_W'(PAGE_BYTES);
  localparam logic [CW-1:0]     FULL_CNT = CW'(RUN_DEPTH);

  // sequencer state
  seq_state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0] page_r, page_nxt;
  status_t           status_r, status_nxt;

  // request beat held for the execute cycle
  op_t               op_r;
  rtype_t            rtype_r;
  logic [ADDR_W-1:0] addr_r;
  logic [ADDR_W-1:0] bytes_r;

  logic          accept;
  logic          slot_free;
  logic          exec_fire;
  logic          empty;
  logic          full;
  logic          push_req;
  logic          remainder;
  logic [CW-1:0] count_m1;

  // run RAM ports
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [RW-1:0] ram_wdata, ram_rdata;
  logic [ADDR_W-1:0] rd_base, rd_len;

  tot_ctl_t tot_ctl;
  tot_t     totals;

  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign exec_fire = (state_r == S_EXEC) && slot_free;
  assign empty     = (count_r == '0);
  assign full      = (count_r == FULL_CNT);
  assign count_m1  = count_r - 1'b1;
  assign rd_base   = ram_rdata[RW-1:ADDR_W];
  assign rd_len    = ram_rdata[ADDR_W-1:0];
  assign remainder = (rd_len > PAGE_LEN);
  assign push_req  = ((op_r == OP_ADD) && (rtype_r == RT_USABLE)) || (op_r == OP_FREE);

  // top-of-stack read goes out with the accept
  assign ram_re    = accept && (op_t'(in_operation) == OP_ALLOC) && !empty;
  assign ram_raddr = count_m1[AW-1:0];

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    page_nxt      = page_r;
    status_nxt    = status_r;
    ram_we        = 1'b0;
    ram_waddr     = count_r[AW-1:0];
    ram_wdata     = {addr_r, (op_r == OP_FREE) ? PAGE_LEN : bytes_r};
    in_ready      = 1'b0;
    tot_ctl.en    = 1'b0;
    tot_ctl.op    = op_r;
    tot_ctl.rtype = rtype_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_fire) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          page_nxt      = '0;
          status_nxt    = ST_OK;
          tot_ctl.en    = 1'b1;
          unique case (op_r)
            OP_ADD, OP_FREE: begin
              if (push_req) begin
                if (full) begin
                  status_nxt = ST_FULL;
                end else begin
                  ram_we    = 1'b1;
                  count_nxt = count_r + 1'b1;
                end
              end
            end
            OP_ALLOC: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
                tot_ctl.en = 1'b0;
              end else begin
                page_nxt = rd_base;
                // remainder reuses the popped slot, so the count holds
                if (remainder) begin
                  ram_we    = 1'b1;
                  ram_waddr = count_m1[AW-1:0];
                  ram_wdata = {rd_base + PAGE_LEN, rd_len - PAGE_LEN};
                end else begin
                  count_nxt = count_m1;
                end
              end
            end
            OP_NONE: ;
            default: ;
          endcase
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r   <= page_nxt;
    status_r <= status_nxt;
    if (accept) begin
      op_r    <= op_t'(in_operation);
      rtype_r <= rtype_t'(in_region_type);
      addr_r  <= in_address;
      bytes_r <= in_region_bytes;
    end
  end

  prsa_ram #(
    .WIDTH (RW),
    .DEPTH (RUN_DEPTH)
  ) u_run_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // totals only move on exec_fire, which needs a free result slot,
  // so they double as the result payload
  prsa_totals #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_totals (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (tot_ctl),
    .bytes  (bytes_r),
    .totals (totals)
  );

  assign out_valid             = out_valid_r;
  assign out_frame_base        = page_r;
  assign out_status            = status_r;
  assign out_overall_bytes     = totals.overall;
  assign out_usable_bytes      = totals.usable;
  assign out_reserved_bytes    = totals.reserved;
  assign out_bad_bytes         = totals.bad;
  assign out_kernel_bytes      = totals.kernel;
  assign out_framebuffer_bytes = totals.framebuffer;
  assign out_reclaimable_bytes = totals.reclaimable;

  // stack never overfills
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("run count above depth");

  // no second beat taken while one is in execute
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("beat accepted during execute");

  // failed allocation reports no page
  a_empty_no_page: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r == ST_EMPTY)) |-> (page_r == '0))
    else $error("frame base on empty allocation");

  // a dropped push only happens on a full stack, which stays full
  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_fire && push_req && full) |=> (count_r == FULL_CNT) && (status_r == ST_FULL))
    else $error("dropped push without full stack");

  // RAM is never written outside execute
  a_we_exec: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> exec_fire)
    else $error("run RAM written outside execute");

endmodule

[design/prsa_ram.sv]
module prsa_ram import prsa_pkg::*; #(
  parameter int unsigned WIDTH = 104,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/prsa_totals.sv]
module prsa_totals import prsa_pkg::*; #(
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tot_ctl_t          ctl,
  input  logic [ADDR_W-1:0] bytes,
  output tot_t              totals
);

  localparam logic [ADDR_W-1:0] PAGE_LEN = ADDR_W'(PAGE_BYTES);

  tot_t tot_r;
  tot_t tot_nxt;

  always_comb begin
    tot_nxt = tot_r;
    if (ctl.en) begin
      unique case (ctl.op)
        OP_ADD: begin
          tot_nxt.overall = sat_add(tot_r.overall, bytes);
          unique case (ctl.rtype)
            RT_USABLE:         tot_nxt.usable      = sat_add(tot_r.usable, bytes);
            RT_RESERVED:       tot_nxt.reserved    = sat_add(tot_r.reserved, bytes);
            RT_ACPI_RECLAIM,
            RT_LOADER_RECLAIM: tot_nxt.reclaimable = sat_add(tot_r.reclaimable, bytes);
            RT_BAD:            tot_nxt.bad         = sat_add(tot_r.bad, bytes);
            RT_KERNEL:         tot_nxt.kernel      = sat_add(tot_r.kernel, bytes);
            RT_FRAMEBUFFER:    tot_nxt.framebuffer = sat_add(tot_r.framebuffer, bytes);
            RT_ACPI_NVS:       ; // overall only
            default:           ;
          endcase
        end
        OP_ALLOC: begin
          tot_nxt.usable = (tot_r.usable > PAGE_LEN) ? tot_r.usable - PAGE_LEN : '0;
        end
        OP_FREE: begin
          tot_nxt.usable = sat_add(tot_r.usable, PAGE_LEN);
        end
        OP_NONE: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tot_r <= '0;
    end else begin
      tot_r <= tot_nxt;
    end
  end

  assign totals = tot_r;

endmodule

[bench/tb_page_run_stack_allocator.sv]
module tb_page_run_stack_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import prsa_pkg::*;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned PAGE  = 4096;
  localparam logic [ADDR_W-1:0] ALL_ONES = {ADDR_W{1'b1}};

  // ---------------------------------------------------------------------------
  // DUT hookup
  // ---------------------------------------------------------------------------
  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        in_operation;
  logic [2:0]        in_region_type;
  logic [ADDR_W-1:0] in_address;
  logic [ADDR_W-1:0] in_region_bytes;
  logic              out_valid;
  logic              out_ready;
  logic [ADDR_W-1:0] out_frame_base;
  logic [1:0]        out_status;
  logic [ADDR_W-1:0] out_overall_bytes;
  logic [ADDR_W-1:0] out_usable_bytes;
  logic [ADDR_W-1:0] out_reserved_bytes;
  logic [ADDR_W-1:0] out_bad_bytes;
  logic [ADDR_W-1:0] out_kernel_bytes;
  logic [ADDR_W-1:0] out_framebuffer_bytes;
  logic [ADDR_W-1:0] out_reclaimable_bytes;

  page_run_stack_allocator #(
    .RUN_DEPTH (DEPTH),
    .PAGE_BYTES(PAGE)
  ) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_operation         (in_operation),
    .in_region_type       (in_region_type),
    .in_address           (in_address),
    .in_region_bytes      (in_region_bytes),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_frame_base       (out_frame_base),
    .out_status           (out_status),
    .out_overall_bytes    (out_overall_bytes),
    .out_usable_bytes     (out_usable_bytes),
    .out_reserved_bytes   (out_reserved_bytes),
    .out_bad_bytes        (out_bad_bytes),
    .out_kernel_bytes     (out_kernel_bytes),
    .out_framebuffer_bytes(out_framebuffer_bytes),
    .out_reclaimable_bytes(out_reclaimable_bytes)
  );

  // ---------------------------------------------------------------------------
  // Allocator shadow: free-run stack plus the seven byte totals
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [ADDR_W-1:0] page;
    status_t           status;
    logic [ADDR_W-1:0] overall;
    logic [ADDR_W-1:0] usable;
    logic [ADDR_W-1:0] reserved;
    logic [ADDR_W-1:0] bad;
    logic [ADDR_W-1:0] kernel;
    logic [ADDR_W-1:0] fb;
    logic [ADDR_W-1:0] reclaim;
  } alloc_beat_t;

  logic [ADDR_W-1:0] shadow_base [DEPTH];
  logic [ADDR_W-1:0] shadow_len  [DEPTH];
  int unsigned       shadow_runs;
  alloc_beat_t       shadow_tot;      // page/status unused, totals only

  alloc_beat_t owed_results[$];       // expected result beats, oldest first

  int errors;
  int n_checked, n_add, n_alloc, n_empty, n_free, n_full, n_none;

  // knobs shared with the driver and the receiver
  bit idle_in;
  bit idle_out;
  int out_hold_cycles;

  function automatic logic [ADDR_W-1:0] clamp_sum(logic [ADDR_W-1:0] a,
                                                  logic [ADDR_W-1:0] b);
    logic [ADDR_W:0] wide;
    wide = a + b + {(ADDR_W+1){1'b0}};
    if (wide > {1'b0, ALL_ONES}) return ALL_ONES;
    return wide[ADDR_W-1:0];
  endfunction

  function automatic status_t run_push(logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] len);
    if (shadow_runs >= DEPTH) return ST_FULL;   // dropped, caller flags it
    shadow_base[shadow_runs] = base;
    shadow_len[shadow_runs]  = len;
    shadow_runs++;
    return ST_OK;
  endfunction

  // Apply one accepted request to the shadow and return the beat it must produce.
  function automatic alloc_beat_t apply_request(op_t op, rtype_t rt,
                                                logic [ADDR_W-1:0] addr,
                                                logic [ADDR_W-1:0] bytes);
    alloc_beat_t      r;
    logic [ADDR_W-1:0] top_base;
    logic [ADDR_W-1:0] top_len;
    r.page   = '0;
    r.status = ST_OK;
    case (op)
      OP_ADD: begin
        n_add++;
        shadow_tot.overall = clamp_sum(shadow_tot.overall, bytes);
        case (rt)
          RT_USABLE: begin
            shadow_tot.usable = clamp_sum(shadow_tot.usable, bytes);
            r.status = run_push(addr, bytes);
          end
          RT_RESERVED:       shadow_tot.reserved = clamp_sum(shadow_tot.reserved, bytes);
          RT_ACPI_RECLAIM,
          RT_LOADER_RECLAIM: shadow_tot.reclaim  = clamp_sum(shadow_tot.reclaim, bytes);
          RT_BAD:            shadow_tot.bad      = clamp_sum(shadow_tot.bad, bytes);
          RT_KERNEL:         shadow_tot.kernel   = clamp_sum(shadow_tot.kernel, bytes);
          RT_FRAMEBUFFER:    shadow_tot.fb       = clamp_sum(shadow_tot.fb, bytes);
          default: ;         // acpi nvs lands in the overall total only
        endcase
      end
      OP_ALLOC: begin
        n_alloc++;
        if (shadow_runs == 0) begin
          r.status = ST_EMPTY;
          n_empty++;
        end else begin
          shadow_runs--;
          top_base = shadow_base[shadow_runs];
          top_len  = shadow_len[shadow_runs];
          // remainder beyond the first page goes back on top; base wraps at 52 bits
          if (top_len > PAGE)
            void'(run_push(top_base + ADDR_W'(PAGE), top_len - ADDR_W'(PAGE)));
          r.page = top_base;
          shadow_tot.usable = (shadow_tot.usable > PAGE) ?
                              shadow_tot.usable - ADDR_W'(PAGE) : '0;
        end
      end
      OP_FREE: begin
        n_free++;
        r.status = run_push(addr, ADDR_W'(PAGE));
        shadow_tot.usable = clamp_sum(shadow_tot.usable, ADDR_W'(PAGE));
      end
      default: n_none++;    // unused opcode: no state change
    endcase
    if (r.status == ST_FULL) n_full++;
    r.overall  = shadow_tot.overall;
    r.usable   = shadow_tot.usable;
    r.reserved = shadow_tot.reserved;
    r.bad      = shadow_tot.bad;
    r.kernel   = shadow_tot.kernel;
    r.fb       = shadow_tot.fb;
    r.reclaim  = shadow_tot.reclaim;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset, watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // generous bound: ~2k beats, worst gaps and stalls, plus the long hold
  initial begin
    #(5_000_000);
    $display("tb_page_run_stack_allocator: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall before each beat, plus an optional long hold
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (out_hold_cycles > 0) begin
        // long back-pressure, counted here so the sender keeps pushing meanwhile
        out_ready = 1'b0;
        repeat (out_hold_cycles) @(negedge clk);
        out_hold_cycles = 0;
      end
      stall = idle_out ? $urandom_range(0, 14) : 0;
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every out beat against the oldest expectation
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [ADDR_W-1:0] exp_v,
                                      logic [ADDR_W-1:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s mismatch: expected 0x%h, got 0x%h", name, exp_v, got_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    alloc_beat_t e;
    if (rst_n && out_valid && out_ready) begin
      if (owed_results.size() == 0) begin
        $error("result beat with nothing expected (frame 0x%h status %0d)",
               out_frame_base, out_status);
        errors++;
      end else begin
        e = owed_results.pop_front();
        n_checked++;
        check_field("frame_base",        e.page,        out_frame_base);
        check_field("status",            ADDR_W'(e.status), ADDR_W'(out_status));
        check_field("overall_bytes",     e.overall,     out_overall_bytes);
        check_field("usable_bytes",      e.usable,      out_usable_bytes);
        check_field("reserved_bytes",    e.reserved,    out_reserved_bytes);
        check_field("bad_bytes",         e.bad,         out_bad_bytes);
        check_field("kernel_bytes",      e.kernel,      out_kernel_bytes);
        check_field("framebuffer_bytes", e.fb,          out_framebuffer_bytes);
        check_field("reclaimable_bytes", e.reclaim,     out_reclaimable_bytes);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver helpers
  // ---------------------------------------------------------------------------
  function automatic logic [ADDR_W-1:0] rand52();
    return ADDR_W'({$urandom, $urandom});
  endfunction

  // One request beat. Valid stays up from the previous beat when there is no gap,
  // so back-to-back beats never see valid dropped and raised in one step.
  task automatic send_beat(op_t op, rtype_t rt, logic [ADDR_W-1:0] addr,
                           logic [ADDR_W-1:0] bytes);
    int gap;
    gap = idle_in ? $urandom_range(0, 14) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        = 1'b1;
    in_operation    = op;
    in_region_type  = rt;
    in_address      = addr;
    in_region_bytes = bytes;
    do @(posedge clk); while (!in_ready);
    owed_results.push_back(apply_request(op, rt, addr, bytes));
  endtask

  // Sender goes quiet until every owed beat is back.
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // allocate from an empty stack, unused opcode with both random and all-ones fields
  task automatic test_empty_and_unused();
    send_beat(OP_ALLOC, RT_USABLE, rand52(), rand52());
    send_beat(OP_NONE, rtype_t'($urandom_range(0, 7)), rand52(), rand52());
    send_beat(OP_NONE, RT_FRAMEBUFFER, ALL_ONES, ALL_ONES);
    drain_results();
  endtask

  // zero-length run, exactly-one-page run, freed page: each popped whole.
  // The zero run also drives usable below one page so the decrement clamps at zero.
  task automatic test_short_runs();
    send_beat(OP_ADD,   RT_USABLE, rand52(), '0);
    send_beat(OP_ALLOC, RT_USABLE, '0, '0);
    send_beat(OP_ADD,   RT_USABLE, rand52(), ADDR_W'(PAGE));
    send_beat(OP_ALLOC, RT_KERNEL, '0, '0);
    send_beat(OP_FREE,  RT_USABLE, ADDR_W'(PAGE) * 5, rand52());
    send_beat(OP_ALLOC, RT_USABLE, '0, '0);
    drain_results();
  endtask

  // multi-page run near the top of the address space: remainder base wraps
  task automatic test_remainder_wrap();
    send_beat(OP_ADD, RT_USABLE, ALL_ONES - 100, ADDR_W'(3 * PAGE + 7));
    repeat (4) send_beat(OP_ALLOC, RT_USABLE, '0, '0);
    drain_results();
  endtask

  // Fill the stack while the receiver holds off, so in_ready backs up,
  // then overflow with a free and a usable add, then pop it empty again.
  task automatic test_stack_full();
    while (shadow_runs != 0) send_beat(OP_ALLOC, RT_USABLE, '0, '0);
    drain_results();
    out_hold_cycles = 300;
    for (int i = 0; i < DEPTH; i++)
      send_beat(OP_FREE, rtype_t'($urandom_range(0, 7)),
                {rand52()} & ~ADDR_W'(PAGE - 1), rand52());
    send_beat(OP_FREE, RT_USABLE, rand52(), '0);                  // dropped
    send_beat(OP_ADD,  RT_USABLE, rand52(), ADDR_W'(8 * PAGE));   // dropped, totals move
    repeat (DEPTH + 1) send_beat(OP_ALLOC, RT_USABLE, '0, '0);    // last one hits empty
    drain_results();
  endtask

  // Mostly realistic traffic: page-multiple regions, page-aligned frees,
  // alloc/free ratio varying per segment so the stack depth wanders.
  task automatic test_random_traffic(int segments, int per_segment);
    int          alloc_pct, pick;
    op_t         op;
    rtype_t      rt;
    logic [ADDR_W-1:0] addr, bytes;
    for (int s = 0; s < segments; s++) begin
      // one segment with no idling anywhere, the rest mixed
      idle_in   = (s == 1) ? 1'b0 : ($urandom_range(0, 2) != 0);
      idle_out  = (s == 1) ? 1'b0 : ($urandom_range(0, 2) != 0);
      alloc_pct = $urandom_range(20, 60);
      for (int i = 0; i < per_segment; i++) begin
        pick  = $urandom_range(0, 99);
        rt    = rtype_t'($urandom_range(0, 7));
        addr  = rand52();
        bytes = rand52();
        if (pick < 4) begin
          op = OP_NONE;
        end else if (pick < 4 + alloc_pct) begin
          op = OP_ALLOC;
        end else if ($urandom_range(0, 1) == 0) begin
          op = OP_FREE;
          if ($urandom_range(0, 4) != 0) addr &= ~ADDR_W'(PAGE - 1);
        end else begin
          op = OP_ADD;
          if ($urandom_range(0, 1) == 0) rt = RT_USABLE;
          // keep totals mostly clear of saturation, which sticks for the run
          pick = $urandom_range(0, 99);
          if (pick < 45)      bytes = ADDR_W'(PAGE) * $urandom_range(0, 12);
          else if (pick < 70) bytes = ADDR_W'($urandom_range(0, 5 * PAGE));
          else if (pick < 90) bytes = ADDR_W'($urandom);
          else                bytes = bytes & ADDR_W'(44'hFFF_FFFF_FFFF);
        end
        send_beat(op, rt, addr, bytes);
      end
      if (s % 4 == 3) drain_results();
    end
    drain_results();
    idle_in  = 1'b1;
    idle_out = 1'b1;
  endtask

  // Max-length regions of every type, twice where needed, so each total pins
  // at all-ones. Runs last since nothing brings a saturated total back down
  // except usable, which the closing allocs pull off the ceiling.
  task automatic test_saturation();
    for (int t = 0; t < 8; t++)
      send_beat(OP_ADD, rtype_t'(t), rand52(), ALL_ONES);
    send_beat(OP_ADD, RT_RESERVED,    rand52(), ALL_ONES);
    send_beat(OP_ADD, RT_BAD,         rand52(), ALL_ONES);
    send_beat(OP_ADD, RT_KERNEL,      rand52(), ALL_ONES);
    send_beat(OP_ADD, RT_FRAMEBUFFER, rand52(), ALL_ONES);
    send_beat(OP_ADD, RT_USABLE,      ALL_ONES, ALL_ONES);
    repeat (3) send_beat(OP_ALLOC, RT_USABLE, '0, '0);
    send_beat(OP_FREE, RT_USABLE, ALL_ONES, '0);
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    // everything known from time zero
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_operation    = OP_NONE;
    in_region_type  = RT_USABLE;
    in_address      = '0;
    in_region_bytes = '0;
    idle_in         = 1'b1;
    idle_out        = 1'b1;
    out_hold_cycles = 0;
    errors          = 0;
    n_checked = 0; n_add = 0; n_alloc = 0; n_empty = 0;
    n_free = 0; n_full = 0; n_none = 0;
    shadow_runs = 0;
    shadow_tot  = '{default: '0, status: ST_OK};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_and_unused();
    test_short_runs();
    test_remainder_wrap();
    test_stack_full();
    test_random_traffic(17, 100);
    test_saturation();

    // settle: nothing should trickle out after the last owed beat
    @(negedge clk);
    in_valid = 1'b0;
    repeat (20) @(posedge clk);

    $display("Checked %0d result beats: %0d region adds, %0d allocs (%0d on empty stack),",
             n_checked, n_add, n_alloc, n_empty);
    $display("  %0d frees, %0d unused-op beats, %0d pushes dropped on a full stack.",
             n_free, n_none, n_full);
    if (errors == 0 && owed_results.size() == 0) begin
      $display("tb_page_run_stack_allocator: PASS");
    end else begin
      if (owed_results.size() != 0)
        $error("%0d expected beats never arrived", owed_results.size());
      $display("tb_page_run_stack_allocator: FAIL");
    end
    $finish;
  end

endmodule

[page_run_stack_allocator.f]
design/prsa_pkg.sv
design/prsa_ram.sv
design/prsa_totals.sv
design/page_run_stack_allocator.sv
bench/tb_page_run_stack_allocator.sv
